@@ rtl/srf_pkg.sv @@
// ----------------------------------------------------------------------------
// srf_pkg
// shared constants and types of the substring removal filter
// ----------------------------------------------------------------------------
package srf_pkg;

    localparam int MAX_PATTERN_DEF = 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int CHAR_W     = 8;
    localparam int LEN_W      = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd1;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_SHIFT,
        CELL_LOAD
    } srf_cell_op_t;

    typedef enum logic [2:0] {
        WIN_HOLD,
        WIN_SHIFT,
        WIN_APPEND,
        WIN_APPSHIFT
    } srf_win_mode_t;

    typedef struct packed {
        logic hold_eq;
        logic shift_eq;
        logic in_eq;
    } srf_cell_status_t;

endpackage

@@ rtl/srf_if.sv @@
// ----------------------------------------------------------------------------
// srf_if
// text, result and configuration channels of the substring removal filter
// ----------------------------------------------------------------------------
interface srf_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       char_valid;
    logic       last_in;

    modport source (output valid, char_in, char_valid, last_in, input ready);
    modport sink (input valid, char_in, char_valid, last_in, output ready);
endinterface

interface srf_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_out;
    logic       out_valid;
    logic       last_out;

    modport source (output valid, char_out, out_valid, last_out, input ready);
    modport sink (input valid, char_out, out_valid, last_out, output ready);
endinterface

interface srf_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [srf_pkg::CFG_IDX_W-1:0]  index;
    logic [srf_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/srf_cell.sv @@
// ----------------------------------------------------------------------------
// srf_cell
// one window byte: holds, takes its neighbor's byte or loads the text byte,
// and compares against its pattern byte
// ----------------------------------------------------------------------------
module srf_cell (
    input  logic                      clk,
    input  srf_pkg::srf_cell_op_t     op,
    input  logic [7:0]                in_char,
    input  logic [7:0]                next_char,
    input  logic [7:0]                pat_char,
    output logic [7:0]                cell_char,
    output srf_pkg::srf_cell_status_t status
);
    import srf_pkg::*;

    logic [7:0] char_reg;
    logic [7:0] char_next;

    always_comb
    begin
        unique case (op)
            CELL_HOLD:  char_next = char_reg;
            CELL_SHIFT: char_next = next_char;
            CELL_LOAD:  char_next = in_char;
            default:    char_next = char_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
    end

    assign cell_char       = char_reg;
    assign status.hold_eq  = (char_reg == pat_char);
    assign status.shift_eq = (next_char == pat_char);
    assign status.in_eq    = (in_char == pat_char);

endmodule

@@ rtl/substring_removal_filter.sv @@
// ----------------------------------------------------------------------------
// substring_removal_filter: text is registered in the input stage, results in
// the result stage; one text byte and one result per cycle while the result
// port does not stall and no drain runs; end of text drains every window byte,
// up to MAX_PATTERN; a shortened pattern drains the excess bytes likewise
// reset clears pattern, window count and both handshake stages; no sweep
// ----------------------------------------------------------------------------
module substring_removal_filter #(
    parameter int MAX_PATTERN = srf_pkg::MAX_PATTERN_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    srf_text_if.sink      text,
    srf_result_if.source  result,
    srf_cfg_if.sink       cfg
);
    import srf_pkg::*;

    localparam int CNT_W = $clog2(MAX_PATTERN + 1);
    localparam int PAT_W = 8 * MAX_PATTERN;

    logic [PAT_W-1:0] pattern_bytes_reg;
    logic [LEN_W-1:0] pattern_length_reg;
    logic [CNT_W-1:0] eff_len;

    logic             item_valid_reg;
    logic [7:0]       item_char_reg;
    logic             item_cv_reg;
    logic             item_last_reg;

    logic             res_valid_reg;
    logic [7:0]       out_char_reg;
    logic             out_flag_reg;
    logic             out_last_reg;

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    logic             step;
    logic             emit;
    logic [7:0]       emit_char;
    logic             emit_flag;
    logic             emit_last;
    logic             consume;
    logic             to_flush;
    logic             accept;
    logic             m_ins;
    logic             m_shift;
    srf_win_mode_t    mode;

    srf_cell_op_t     cell_op [MAX_PATTERN];
    logic [7:0]       cell_char [MAX_PATTERN];
    srf_cell_status_t cell_stat [MAX_PATTERN];

    // configuration
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_bytes_reg  <= '0;
            pattern_length_reg <= '0;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == CFG_PATTERN_BYTES)
            begin
                pattern_bytes_reg <= cfg.data[PAT_W-1:0];
            end
            else if (cfg.index == CFG_PATTERN_LENGTH)
            begin
                pattern_length_reg <= cfg.data[LEN_W-1:0];
            end
        end
    end

    assign eff_len = (pattern_length_reg > LEN_W'(MAX_PATTERN)) ?
                     CNT_W'(MAX_PATTERN) : CNT_W'(pattern_length_reg);

    // cell row
    genvar g;
    generate
        for (g = 0; g < MAX_PATTERN; g++)
        begin : g_cell
            logic [7:0] nb;
            if (g == MAX_PATTERN - 1)
            begin : g_end
                assign nb = 8'h00;
            end
            else
            begin : g_mid
                assign nb = cell_char[g+1];
            end

            srf_cell u_cell (
                .clk       (clk),
                .op        (cell_op[g]),
                .in_char   (item_char_reg),
                .next_char (nb),
                .pat_char  (pattern_bytes_reg[8*g +: 8]),
                .cell_char (cell_char[g]),
                .status    (cell_stat[g])
            );
        end
    endgenerate

    // window match against the pattern, with and without a shift
    always_comb
    begin
        m_ins   = 1'b1;
        m_shift = 1'b1;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            if ((CNT_W+1)'(i) + (CNT_W+1)'(1) < {1'b0, eff_len})
            begin
                m_ins   = m_ins & cell_stat[i].hold_eq;
                m_shift = m_shift & cell_stat[i].shift_eq;
            end
            else if ((CNT_W+1)'(i) + (CNT_W+1)'(1) == {1'b0, eff_len})
            begin
                m_ins   = m_ins & cell_stat[i].in_eq;
                m_shift = m_shift & cell_stat[i].in_eq;
            end
        end
    end

    // step control
    assign step = item_valid_reg && (!res_valid_reg || result.ready);

    always_comb
    begin
        logic emitted;
        emit      = 1'b0;
        emit_char = cell_char[0];
        emit_flag = 1'b1;
        emit_last = 1'b0;
        consume   = 1'b0;
        to_flush  = 1'b0;
        mode      = WIN_HOLD;
        cnt_next  = cnt_reg;
        emitted   = 1'b0;

        if (step)
        begin
            if (item_cv_reg)
            begin
                if (eff_len == '0)
                begin
                    emit = 1'b1;
                    if (cnt_reg != '0)
                    begin
                        mode     = WIN_SHIFT;
                        cnt_next = cnt_reg - CNT_W'(1);
                    end
                    else
                    begin
                        emit_char = item_char_reg;
                        emit_last = item_last_reg;
                        consume   = 1'b1;
                    end
                end
                else if (cnt_reg >= eff_len)
                begin
                    // drain bytes beyond a shortened pattern
                    emit     = 1'b1;
                    mode     = WIN_SHIFT;
                    cnt_next = cnt_reg - CNT_W'(1);
                    if (cnt_reg == eff_len && item_last_reg && m_shift)
                    begin
                        emit_last = 1'b1;
                        cnt_next  = '0;
                        consume   = 1'b1;
                    end
                end
                else
                begin
                    if (cnt_reg + CNT_W'(1) == eff_len)
                    begin
                        if (m_ins)
                        begin
                            cnt_next = '0;
                        end
                        else
                        begin
                            emitted  = 1'b1;
                            mode     = WIN_APPSHIFT;
                            cnt_next = cnt_reg;
                            if (cnt_reg == '0)
                            begin
                                emit_char = item_char_reg;
                            end
                        end
                    end
                    else
                    begin
                        mode     = WIN_APPEND;
                        cnt_next = cnt_reg + CNT_W'(1);
                    end

                    emit = emitted;
                    if (!item_last_reg)
                    begin
                        consume = 1'b1;
                    end
                    else if (cnt_next != '0)
                    begin
                        to_flush = 1'b1;
                    end
                    else
                    begin
                        consume   = 1'b1;
                        emit      = 1'b1;
                        emit_last = 1'b1;
                        if (!emitted)
                        begin
                            emit_char = 8'h00;
                            emit_flag = 1'b0;
                        end
                    end
                end
            end
            else if (item_last_reg)
            begin
                emit      = 1'b1;
                emit_last = (cnt_reg <= CNT_W'(1));
                consume   = (cnt_reg <= CNT_W'(1));
                if (cnt_reg != '0)
                begin
                    mode     = WIN_SHIFT;
                    cnt_next = cnt_reg - CNT_W'(1);
                end
                else
                begin
                    emit_char = 8'h00;
                    emit_flag = 1'b0;
                end
            end
            else
            begin
                consume = 1'b1;
            end
        end
    end

    // per-cell operation
    always_comb
    begin
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            cell_op[i] = CELL_HOLD;
            unique case (mode)
                WIN_SHIFT:
                begin
                    cell_op[i] = CELL_SHIFT;
                end
                WIN_APPEND:
                begin
                    if ((CNT_W+1)'(i) == {1'b0, cnt_reg})
                    begin
                        cell_op[i] = CELL_LOAD;
                    end
                end
                WIN_APPSHIFT:
                begin
                    if ((CNT_W+1)'(i) + (CNT_W+1)'(1) < {1'b0, cnt_reg})
                    begin
                        cell_op[i] = CELL_SHIFT;
                    end
                    else if ((CNT_W+1)'(i) + (CNT_W+1)'(1) == {1'b0, cnt_reg})
                    begin
                        cell_op[i] = CELL_LOAD;
                    end
                end
                default:
                begin
                    cell_op[i] = CELL_HOLD;
                end
            endcase
        end
    end

    // input stage
    assign text.ready = !item_valid_reg || (step && consume);
    assign accept     = text.valid && text.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
            cnt_reg        <= '0;
        end
        else
        begin
            if (accept)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (step && consume)
            begin
                item_valid_reg <= 1'b0;
            end

            if (step && emit)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end

            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_char_reg <= text.char_in;
            item_cv_reg   <= text.char_valid;
            item_last_reg <= text.last_in;
        end
        else if (to_flush)
        begin
            item_cv_reg <= 1'b0;
        end

        if (step && emit)
        begin
            out_char_reg <= emit_char;
            out_flag_reg <= emit_flag;
            out_last_reg <= emit_last;
        end
    end

    assign result.valid     = res_valid_reg;
    assign result.char_out  = out_char_reg;
    assign result.out_valid = out_flag_reg;
    assign result.last_out  = out_last_reg;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_PATTERN))
        else $error("window count beyond pattern maximum");

    a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !out_flag_reg |-> out_last_reg)
        else $error("end marker without last");

    a_last_empties: assert property (@(posedge clk) disable iff (!rst_n)
        step && emit && emit_last |=> cnt_reg == '0)
        else $error("window not empty after last result");

    a_end_gives_last: assert property (@(posedge clk) disable iff (!rst_n)
        step && consume && item_last_reg |-> emit && emit_last)
        else $error("end of text retired without last result");
`endif

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: substring removal filter testbench
// streams texts through the filter and checks every result transaction
// against an in-bench model of the byte window, over several pattern
// settings, mid-text length changes and four handshake idling modes
// ----------------------------------------------------------------------------
module tb;

    import srf_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 6;
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASE_ITEMS   = 45;
    localparam int RANDOM_PHASES = 8;
    localparam int REPORT_MAX    = 10;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              has_char;
        logic              end_text;
    } text_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              ok;
        logic              last;
    } text_result_t;

    logic clk;
    logic rst_n;

    srf_text_if   text_ch ();
    srf_result_if result_ch ();
    srf_cfg_if    cfg_ch ();

    substring_removal_filter dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // mirrored pattern registers and byte window
    logic [CFG_DATA_W-1:0] pat_bytes = '0;
    logic [LEN_W-1:0]      pat_len   = '0;
    logic [CHAR_W-1:0]     win [MAX_PATTERN_DEF];
    int                    win_count = 0;

    text_item_t   pending_text[$];
    text_item_t   on_wire;
    text_result_t step_out[$];
    text_result_t awaited_results[$];
    text_result_t got_result;
    text_result_t want_result;

    int send_idle_pct  = 0;
    int stall_pct      = 0;
    int cycle_count    = 0;
    int mismatch_count = 0;
    int items_accepted = 0;
    int results_seen   = 0;
    int cfg_writes     = 0;

    function automatic text_result_t make_result(logic [CHAR_W-1:0] ch, logic ok);
        text_result_t r;
        r.ch   = ch;
        r.ok   = ok;
        r.last = 1'b0;
        return r;
    endfunction

    function automatic void emit_oldest_byte();
        if (win_count == 0)
            return;
        step_out.push_back(make_result(win[0], 1'b1));
        for (int i = 1; i < win_count; i++)
            win[i-1] = win[i];
        win_count--;
    endfunction

    function automatic void filter_step(text_item_t it);
        int           len;
        logic         hit;
        text_result_t tail;
        len = (pat_len > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : int'(pat_len);
        step_out.delete();
        if (it.has_char)
        begin
            if (len == 0)
            begin
                while (win_count > 0)
                    emit_oldest_byte();
                step_out.push_back(make_result(it.ch, 1'b1));
            end
            else
            begin
                while (win_count >= len)
                    emit_oldest_byte();
                if (win_count < MAX_PATTERN_DEF)
                begin
                    win[win_count] = it.ch;
                    win_count++;
                end
                if (win_count == len)
                begin
                    hit = 1'b1;
                    for (int i = 0; i < len; i++)
                        if (win[i] != pat_bytes[8*i +: 8])
                            hit = 1'b0;
                    if (hit)
                        win_count = 0;
                    else
                        emit_oldest_byte();
                end
            end
        end
        if (it.end_text)
        begin
            while (win_count > 0)
                emit_oldest_byte();
            if (step_out.size() == 0)
                step_out.push_back(make_result('0, 1'b0));
            tail = step_out.pop_back();
            tail.last = 1'b1;
            step_out.push_back(tail);
        end
        foreach (step_out[i])
            awaited_results.push_back(step_out[i]);
    endfunction

    function automatic void note_mismatch(string what, text_result_t want,
                                          text_result_t got);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("mismatch (%s) cycle %0d: expected char %02h valid %b last %b,",
                     what, cycle_count, want.ch, want.ok, want.last,
                     " got char %02h valid %b last %b", got.ch, got.ok, got.last);
    endfunction

    // text driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            text_ch.valid <= 1'b0;
        end
        else
        begin
            if (text_ch.valid && text_ch.ready)
            begin
                filter_step(on_wire);
                items_accepted++;
            end
            if (!text_ch.valid || text_ch.ready)
            begin
                if (pending_text.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    on_wire = pending_text.pop_front();
                    text_ch.valid      <= 1'b1;
                    text_ch.char_in    <= on_wire.ch;
                    text_ch.char_valid <= on_wire.has_char;
                    text_ch.last_in    <= on_wire.end_text;
                end
                else
                begin
                    text_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                got_result.ch   = result_ch.char_out;
                got_result.ok   = result_ch.out_valid;
                got_result.last = result_ch.last_out;
                results_seen++;
                if (awaited_results.size() == 0)
                begin
                    note_mismatch("no transaction expected", '0, got_result);
                end
                else
                begin
                    want_result = awaited_results.pop_front();
                    if (got_result.ch !== want_result.ch
                        || got_result.ok !== want_result.ok
                        || got_result.last !== want_result.last)
                        note_mismatch("field", want_result, got_result);
                end
            end
            result_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, awaited_results.size());
            $display("FAIL substring_removal_filter");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        forever #(CLK_HALF) clk = ~clk;
    end

    function automatic void add_text(logic [CHAR_W-1:0] ch, logic has_char,
                                     logic end_text);
        text_item_t it;
        it.ch       = ch;
        it.has_char = has_char;
        it.end_text = end_text;
        pending_text.push_back(it);
    endfunction

    function automatic void add_byte(logic [CHAR_W-1:0] ch);
        add_text(ch, 1'b1, $urandom_range(9) == 0);
    endfunction

    function automatic void queue_word(string s, logic end_it);
        for (int i = 0; i < s.len(); i++)
            add_text(s[i], 1'b1, end_it && (i == s.len() - 1));
    endfunction

    task automatic set_idle(idle_mode_t mode);
        case (mode)
            IDLE_NONE: begin send_idle_pct = 0;  stall_pct = 0;  end
            IDLE_SEND: begin send_idle_pct = 61; stall_pct = 0;  end
            IDLE_RECV: begin send_idle_pct = 0;  stall_pct = 61; end
            default:   begin send_idle_pct = 16; stall_pct = 16; end
        endcase
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (pending_text.size() > 0 || text_ch.valid || awaited_results.size() > 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx == CFG_PATTERN_BYTES)
            pat_bytes = val;
        else if (idx == CFG_PATTERN_LENGTH)
            pat_len = val[LEN_W-1:0];
        cfg_writes++;
    endtask

    task automatic set_phase_config(int phase);
        logic [CFG_DATA_W-1:0] pb;
        logic [CHAR_W-1:0]     a0;
        logic [CHAR_W-1:0]     a1;
        int                    len;
        a0 = CHAR_W'($urandom_range(255));
        a1 = CHAR_W'($urandom_range(255));
        for (int i = 0; i < MAX_PATTERN_DEF; i++)
            if ($urandom_range(99) < 80)
                pb[8*i +: 8] = $urandom_range(1) ? a0 : a1;
            else
                pb[8*i +: 8] = CHAR_W'($urandom_range(255));
        case (phase)
            0:       begin pb = '1; len = 15; end
            1:       begin pb = '0; len = 8;  end
            2:       len = 3;
            3:       len = 1;
            4:       len = 0;
            5:       len = 6;
            6:       len = 2;
            default: len = $urandom_range(1, 15);
        endcase
        // length-only phases change the pattern length while a text is open
        if (phase % 3 != 0 || phase == 0)
            write_reg(CFG_PATTERN_BYTES, pb);
        write_reg(CFG_PATTERN_LENGTH, CFG_DATA_W'(len));
    endtask

    task automatic queue_random_text(int count);
        int                made;
        int                eff;
        int                r;
        int                k;
        logic [CHAR_W-1:0] b;
        made = 0;
        eff = (pat_len > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : int'(pat_len);
        while (made < count)
        begin
            r = $urandom_range(99);
            b = CHAR_W'($urandom_range(255));
            if (r < 3)
            begin
                add_text(b, 1'b0, 1'b0);
            end
            else if (r < 6)
            begin
                add_text(b, 1'b0, 1'b1);
                made++;
            end
            else if (r < 46 && eff > 0)
            begin
                for (int i = 0; i < eff; i++)
                    add_byte(pat_bytes[8*i +: 8]);
                made += eff;
            end
            else if (r < 64 && eff > 0)
            begin
                k = $urandom_range(1, eff);
                for (int i = 0; i < k; i++)
                    add_byte(pat_bytes[8*i +: 8]);
                made += k;
            end
            else if (r < 86 && eff > 0)
            begin
                k = $urandom_range(1, 3);
                for (int i = 0; i < k; i++)
                    add_byte(pat_bytes[8*$urandom_range(eff - 1) +: 8]);
                made += k;
            end
            else
            begin
                k = $urandom_range(1, 2);
                for (int i = 0; i < k; i++)
                    add_byte(CHAR_W'($urandom_range(255)));
                made += k;
            end
        end
    endtask

    initial
    begin
        rst_n              = 1'b0;
        text_ch.valid      = 1'b0;
        text_ch.char_in    = '0;
        text_ch.char_valid = 1'b0;
        text_ch.last_in    = 1'b0;
        result_ch.ready    = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = '0;
        cfg_ch.data        = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // pass-through after reset, zero byte, ignored item, empty end
        set_idle(IDLE_NONE);
        @(negedge clk);
        add_text(8'h00, 1'b1, 1'b0);
        add_text(8'hff, 1'b1, 1'b1);
        add_text(8'h00, 1'b0, 1'b0);
        add_text(8'h00, 1'b0, 1'b1);
        wait_idle();

        write_reg(CFG_PATTERN_BYTES, 64'h0000_0000_0063_6261);
        write_reg(CFG_PATTERN_LENGTH, 64'd3);
        @(negedge clk);
        queue_word("xabcy", 1'b1);
        queue_word("ababc", 1'b1);
        queue_word("ab", 1'b0);
        add_text(8'h00, 1'b0, 1'b1);
        queue_word("abc", 1'b1);
        queue_word("ab", 1'b0);
        wait_idle();

        // shorten the pattern with two bytes still held
        write_reg(CFG_PATTERN_LENGTH, 64'd1);
        @(negedge clk);
        queue_word("a", 1'b1);
        wait_idle();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            set_phase_config(p);
            set_idle(idle_mode_t'(p % 4));
            @(negedge clk);
            queue_random_text(PHASE_ITEMS);
            wait_idle();
        end

        $display("covered %0d text and %0d result transactions, %0d register writes",
                 items_accepted, results_seen, cfg_writes);
        $display("pattern lengths 0 to 15, mid-text length changes, four idling modes");
        if (mismatch_count == 0)
            $display("PASS substring_removal_filter");
        else
            $display("FAIL substring_removal_filter");
        $finish;
    end

endmodule
